[rtl/core/imm_pkg.sv]
package imm_pkg;

  // Width of the size register and the size that it takes at reset.
  localparam int SIZE_W = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Kind of element carried by an input transaction.
  localparam logic REQ_B = 1'b0;
  localparam logic REQ_A = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] element_value;
  } imm_req_t;

  typedef struct packed {
    logic signed [39:0] product_value;
    logic        [3:0]  row_index;
    logic        [3:0]  col_index;
    logic               row_last;
  } imm_result_t;

  // Fixed-width part of the token that walks along the cell chain.
  typedef struct packed {
    logic               valid;
    logic               is_a;
    logic               row_end;
    logic        [3:0]  row_index;
    logic signed [15:0] value;
  } imm_tok_t;

endpackage

[rtl/core/imm_cell.sv]
module imm_cell import imm_pkg::*; #(
  parameter int N_MAX = 16,
  parameter int CELL  = 0,
  localparam int ADDR_W = (N_MAX > 1) ? $clog2(N_MAX * N_MAX) : 1,
  localparam int CNT_W  = $clog2(N_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic [CNT_W-1:0]  act_size,
  input  imm_tok_t          tok_in,
  input  logic [ADDR_W-1:0] k_in,
  output imm_tok_t          tok_out,
  output logic [ADDR_W-1:0] k_out,
  output logic              res_valid,
  output imm_result_t       res
);

  // The whole of B in flat row-major order of the size in use. Every cell keeps
  // its own copy, so a later size reads the kept elements at the same places.
  logic signed [15:0] mem [N_MAX*N_MAX];
  logic signed [15:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;

  logic               cell_on;
  logic               cell_last;

  logic               s1_valid;
  logic               s1_end;
  logic        [3:0]  s1_row;
  logic signed [15:0] s1_val;

  logic               s2_valid;
  logic               s2_end;
  logic        [3:0]  s2_row;
  logic signed [31:0] s2_prod;

  logic signed [39:0] sum;
  logic signed [39:0] sum_next;

  assign cell_on   = CNT_W'(CELL) < act_size;
  assign cell_last = CNT_W'(CELL) == CNT_W'(act_size - 1'b1);

  // An A element carries the start of its row of B; this cell takes its column.
  assign rd_addr = k_in + ADDR_W'(CELL);

  // The token moves on to the next cell every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_in;
    end
    k_out <= k_in;
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid && (tok_in.is_a == REQ_B)) begin
      mem[k_in] <= tok_in.value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= tok_in.valid && (tok_in.is_a == REQ_A) && cell_on;
      s2_valid <= s1_valid;
    end
    s1_end  <= tok_in.row_end;
    s1_row  <= tok_in.row_index;
    s1_val  <= tok_in.value;
    s2_end  <= s1_end;
    s2_row  <= s1_row;
    s2_prod <= s1_val * rd_data;
  end

  assign sum_next = sum + 40'(s2_prod);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sum       <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= s2_valid && s2_end;
      if (s2_valid) begin
        sum <= s2_end ? '0 : sum_next;
      end
    end
    res.product_value <= sum_next;
    res.row_index     <= s2_row;
    res.col_index     <= 4'(CELL);
    res.row_last      <= cell_last;
  end

endmodule

[rtl/core/integer_matrix_multiply.sv]
// Channel        Direction  Handshake                     Payload
// input          in         start (accepted while !busy)  req      (imm_req_t)
// result         out        result_valid, one cycle each  result   (imm_result_t)
// configuration  in         cfg_we                        cfg_data (matrix size)
//
// A new transaction is taken on every cycle: busy stays low, as each element only
// travels along the chain of column cells and nothing has to wait for it.
// The results of a row of C appear on consecutive cycles, column 0 first, after the
// last A element of that row, as each cell finishes in the cycle after its left
// neighbour.
// Reset is synchronous and sets the size to 16 and every counter and sum to zero;
// the B store inside the cells keeps no reset value.
// The receiver cannot stall the result channel, and nothing here needs it to.
module integer_matrix_multiply import imm_pkg::*; #(
  parameter int N_MAX = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  imm_req_t          req,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  output logic              result_valid,
  output imm_result_t       result
);

  localparam int IDX_W  = (N_MAX > 1) ? $clog2(N_MAX) : 1;
  localparam int CNT_W  = $clog2(N_MAX + 1);
  localparam int ADDR_W = (N_MAX > 1) ? $clog2(N_MAX * N_MAX) : 1;

  logic [SIZE_W-1:0] size_reg;
  logic [CNT_W-1:0]  act_size;
  logic [CNT_W-1:0]  last_idx;

  // The B store is laid out flat in row-major order of the size in use, so the
  // write position is kept flat. The row and column counters only tell when it
  // wraps after size*size elements. For A, a_base is the flat position at which
  // the matching row of B starts.
  logic [IDX_W-1:0]  b_row;
  logic [IDX_W-1:0]  b_col;
  logic [ADDR_W-1:0] b_pos;
  logic [IDX_W-1:0]  a_col;
  logic [IDX_W-1:0]  a_row;
  logic [ADDR_W-1:0] a_base;

  logic              accept;
  logic              b_col_last;
  logic              b_row_last;
  logic              a_col_last;
  logic              a_row_last;

  imm_tok_t          tok  [N_MAX+1];
  logic [ADDR_W-1:0] kk   [N_MAX+1];

  logic              cell_valid [N_MAX];
  imm_result_t       cell_res   [N_MAX];

  logic              sel_valid;
  imm_result_t       sel_res;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // A size of zero behaves as one and anything above N_MAX as N_MAX.
  always_comb begin
    if (size_reg == '0) begin
      act_size = CNT_W'(1);
    end else if (int'(size_reg) > N_MAX) begin
      act_size = CNT_W'(N_MAX);
    end else begin
      act_size = CNT_W'(size_reg);
    end
  end

  assign last_idx   = CNT_W'(act_size - 1'b1);
  assign b_col_last = CNT_W'(b_col) == last_idx;
  assign b_row_last = CNT_W'(b_row) == last_idx;
  assign a_col_last = CNT_W'(a_col) == last_idx;
  assign a_row_last = CNT_W'(a_row) == last_idx;

  // Any write of the size restarts the block; the stored B is kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RESET;
      b_row    <= '0;
      b_col    <= '0;
      b_pos    <= '0;
      a_col    <= '0;
      a_row    <= '0;
      a_base   <= '0;
    end else if (cfg_we) begin
      size_reg <= cfg_data;
      b_row    <= '0;
      b_col    <= '0;
      b_pos    <= '0;
      a_col    <= '0;
      a_row    <= '0;
      a_base   <= '0;
    end else if (accept) begin
      if (req.req_type == REQ_B) begin
        b_pos <= (b_col_last && b_row_last) ? '0 : b_pos + 1'b1;
        if (b_col_last) begin
          b_col <= '0;
          b_row <= b_row_last ? '0 : b_row + 1'b1;
        end else begin
          b_col <= b_col + 1'b1;
        end
      end else begin
        if (a_col_last) begin
          a_col  <= '0;
          a_base <= '0;
          a_row  <= a_row_last ? '0 : a_row + 1'b1;
        end else begin
          a_col  <= a_col + 1'b1;
          a_base <= a_base + ADDR_W'(act_size);
        end
      end
    end
  end

  // The token that enters the first cell. An A element carries the flat position
  // where its row of B starts; a B element carries its own flat position.
  // B elements travel the same chain, so their order against A elements holds.
  always_comb begin
    tok[0].valid     = accept;
    tok[0].is_a      = req.req_type;
    tok[0].row_end   = (req.req_type == REQ_A) && a_col_last;
    tok[0].row_index = 4'(a_row);
    tok[0].value     = req.element_value;
    kk[0]            = (req.req_type == REQ_A) ? a_base : b_pos;
  end

  for (genvar j = 0; j < N_MAX; j++) begin : g_cell
    imm_cell #(
      .N_MAX (N_MAX),
      .CELL  (j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (cfg_we),
      .act_size  (act_size),
      .tok_in    (tok[j]),
      .k_in      (kk[j]),
      .tok_out   (tok[j+1]),
      .k_out     (kk[j+1]),
      .res_valid (cell_valid[j]),
      .res       (cell_res[j])
    );
  end

  // Cells finish on different cycles, so at most one of them offers a result.
  always_comb begin
    sel_valid = 1'b0;
    sel_res   = cell_res[0];
    for (int j = 0; j < N_MAX; j++) begin
      if (cell_valid[j]) begin
        sel_valid = 1'b1;
        sel_res   = cell_res[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= sel_valid;
    end
    result <= sel_res;
  end

endmodule
